// File: rtl/cnet_pkg.sv
// Package: widths, types and constants shared by the cluster edge trim block.
package cnet_pkg;

    localparam int CHANNELS    = 1024;
    localparam int MAX_CLUSTER = 32;

    localparam int DET_W = 4;
    localparam int CH_W  = 10;
    localparam int E_W   = 24;
    localparam int TS_W  = 48;

    localparam int THR_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PEND_AW = (MAX_CLUSTER > 1) ? $clog2(MAX_CLUSTER) : 1;
    localparam int CNT_W   = $clog2(MAX_CLUSTER + 1);
    localparam int PEND_W  = CH_W + E_W + TS_W;

    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_HIT  = 1'b1;

    typedef logic [DET_W-1:0]      t_det;
    typedef logic [CH_W-1:0]       t_ch;
    typedef logic signed [E_W-1:0] t_energy;
    typedef logic [TS_W-1:0]       t_ts;
    typedef logic [CNT_W-1:0]      t_cnt;

    // One classified hit handed from the front end to the back end.
    typedef struct packed {
        logic    acc;     // hit counted within cluster capacity
        logic    above;   // energy above channel threshold
        logic    last;    // end of cluster
        logic    ovf;     // overflow flag of the cluster so far
        t_det    det;
        t_ch     ch;
        t_energy e;
        t_ts     ts;
    } t_cmd;

endpackage

// File: rtl/cnet_if.sv
// Handshake channel interfaces for hit input and trimmed result output.
interface cnet_hit_if import cnet_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    mode;
    t_det    det_id;
    t_ch     channel;
    t_energy energy;
    t_ts     timestamp;
    logic    last_in_cluster;

    modport source (output valid, mode, det_id, channel, energy, timestamp,
                    last_in_cluster, input ready);
    modport sink   (input valid, mode, det_id, channel, energy, timestamp,
                    last_in_cluster, output ready);
endinterface

interface cnet_res_if import cnet_pkg::*; ();
    logic    valid;
    logic    ready;
    t_det    out_det_id;
    t_ch     out_channel;
    t_energy out_energy;
    t_ts     out_timestamp;
    logic    out_last;
    logic    out_overflow;

    modport source (output valid, out_det_id, out_channel, out_energy, out_timestamp,
                    out_last, out_overflow, input ready);
    modport sink   (input valid, out_det_id, out_channel, out_energy, out_timestamp,
                    out_last, out_overflow, output ready);
endinterface

// File: rtl/cluster_noise_edge_trim.sv
// Top level of the cluster edge trim block: front end, command queue, back end.
//
//   channel   dir  modport  payload
//   i_hit     in   sink     mode, det_id, channel, energy, timestamp, last_in_cluster
//   o_res     out  source   out_det_id, out_channel, out_energy, out_timestamp,
//                           out_last, out_overflow
//
// The front end takes one item per cycle while the two-entry queue has room; the
// threshold read is registered. The back end takes one queued hit per cycle while idle
// and sends one result per cycle while o_res takes them; a strong hit that releases
// buffered weak hits keeps it from taking new hits until those results are sent.
// After reset a clearing pass zeroes all CHANNELS (1024) threshold table entries with
// i_hit.ready low. A stalled o_res holds the back end; the queue then fills and stalls i_hit.
module cluster_noise_edge_trim import cnet_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cnet_hit_if.sink   i_hit,
    cnet_res_if.source o_res
);
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd q_in;
    t_cmd q_head;

    cnet_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_hit    (i_hit),
        .o_push   (q_push),
        .o_cmd    (q_in),
        .i_q_full (q_full)
    );

    cnet_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    cnet_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );
endmodule

// File: rtl/cnet_ram.sv
// Generic simple dual-port RAM with registered read.
module cnet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/cnet_queue.sv
// Two-entry command queue between the front end and the back end.
module cnet_queue import cnet_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);
    t_cmd             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QAW:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
endmodule

// File: rtl/cnet_front.sv
// Front end: threshold table, clearing pass, hit classification and cluster capacity.
module cnet_front import cnet_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cnet_hit_if.sink      i_hit,
    output logic          o_push,
    output t_cmd          o_cmd,
    input  logic          i_q_full
);
    logic                r_clr_done;
    logic [THR_AW-1:0]   r_clr_addr;

    logic                r_stg_valid;
    t_det                r_stg_det;
    t_ch                 r_stg_ch;
    t_energy             r_stg_e;
    t_ts                 r_stg_ts;
    logic                r_stg_last;
    logic                r_stg_in_range;

    t_cnt                r_hits;
    logic                r_ovf_seen;

    logic                accept;
    logic                in_range;
    logic                stg_done;
    logic                need_push;
    logic                acc;
    logic                above;
    logic [E_W-1:0]      thr_rdata;
    t_energy             thr;

    logic                thr_we;
    logic [THR_AW-1:0]   thr_waddr;
    logic [E_W-1:0]      thr_wdata;
    logic [THR_AW-1:0]   thr_raddr;
    logic                thr_re;

    assign in_range  = (32'(i_hit.channel) < CHANNELS);
    assign acc       = (r_hits < CNT_W'(MAX_CLUSTER));
    assign need_push = acc || r_stg_last;
    assign stg_done  = r_stg_valid && (!need_push || !i_q_full);

    assign i_hit.ready = r_clr_done && (!r_stg_valid || stg_done);
    assign accept      = i_hit.valid && i_hit.ready;

    // Clearing pass writes zero over the whole table after reset.
    assign thr_we    = !r_clr_done
                       || (accept && (i_hit.mode == MODE_LOAD) && in_range);
    assign thr_waddr = r_clr_done ? THR_AW'(i_hit.channel) : r_clr_addr;
    assign thr_wdata = r_clr_done ? i_hit.energy : '0;
    assign thr_re    = accept && (i_hit.mode == MODE_HIT);
    assign thr_raddr = THR_AW'(i_hit.channel);

    cnet_ram #(
        .WIDTH (E_W),
        .DEPTH (CHANNELS)
    ) u_thr_ram (
        .i_clk   (i_clk),
        .i_we    (thr_we),
        .i_waddr (thr_waddr),
        .i_wdata (thr_wdata),
        .i_re    (thr_re),
        .i_raddr (thr_raddr),
        .o_rdata (thr_rdata)
    );

    assign thr   = r_stg_in_range ? $signed(thr_rdata) : '0;
    assign above = acc && ($signed(r_stg_e) > $signed(thr));

    always_comb begin
        o_cmd.acc    = acc;
        o_cmd.above  = above;
        o_cmd.last   = r_stg_last;
        o_cmd.ovf    = r_ovf_seen || !acc;
        o_cmd.det    = r_stg_det;
        o_cmd.ch     = r_stg_ch;
        o_cmd.e      = r_stg_e;
        o_cmd.ts     = r_stg_ts;
    end
    assign o_push = r_stg_valid && need_push && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_done  <= 1'b0;
            r_clr_addr  <= '0;
            r_stg_valid <= 1'b0;
            r_hits      <= '0;
            r_ovf_seen  <= 1'b0;
        end else begin
            if (!r_clr_done) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == THR_AW'(CHANNELS - 1)) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (thr_re) begin
                r_stg_valid <= 1'b1;
            end else if (stg_done) begin
                r_stg_valid <= 1'b0;
            end
            if (stg_done) begin
                if (r_stg_last) begin
                    r_hits     <= '0;
                    r_ovf_seen <= 1'b0;
                end else if (acc) begin
                    r_hits <= r_hits + 1'b1;
                end else begin
                    r_ovf_seen <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (thr_re) begin
            r_stg_det      <= i_hit.det_id;
            r_stg_ch       <= i_hit.channel;
            r_stg_e        <= i_hit.energy;
            r_stg_ts       <= i_hit.timestamp;
            r_stg_last     <= i_hit.last_in_cluster;
            r_stg_in_range <= in_range;
        end
    end
endmodule

// File: rtl/cnet_back.sv
// Back end: held strong hit, pending weak-hit buffer and result sequencing.
module cnet_back import cnet_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  t_cmd          i_head,
    output logic          o_pop,
    cnet_res_if.source    o_res
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_HELD  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_NEW   = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic          r_held_valid, n_held_valid;
    t_ch           r_held_ch, n_held_ch;
    t_energy       r_held_e, n_held_e;
    t_ts           r_held_ts, n_held_ts;
    t_cnt          r_pcnt, n_pcnt;
    t_cnt          r_idx, n_idx;

    logic          r_out_valid;
    t_det          r_out_det, n_out_det;
    t_ch           r_out_ch, n_out_ch;
    t_energy       r_out_e, n_out_e;
    t_ts           r_out_ts, n_out_ts;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    logic          slot_free;
    logic          emit;
    logic          pw_we;
    logic          pr_re;
    logic [PEND_AW-1:0] pr_addr;
    logic [PEND_W-1:0]  pr_data;
    t_cnt          idx_next;

    assign slot_free = !r_out_valid || o_res.ready;
    assign idx_next  = r_idx + 1'b1;

    cnet_ram #(
        .WIDTH (PEND_W),
        .DEPTH (MAX_CLUSTER)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pw_we),
        .i_waddr (r_pcnt[PEND_AW-1:0]),
        .i_wdata ({i_head.ch, i_head.e, i_head.ts}),
        .i_re    (pr_re),
        .i_raddr (pr_addr),
        .o_rdata (pr_data)
    );

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_held_valid = r_held_valid;
        n_held_ch    = r_held_ch;
        n_held_e     = r_held_e;
        n_held_ts    = r_held_ts;
        n_pcnt       = r_pcnt;
        n_idx        = r_idx;
        o_pop        = 1'b0;
        pw_we        = 1'b0;
        pr_re        = 1'b0;
        pr_addr      = idx_next[PEND_AW-1:0];
        emit         = 1'b0;
        n_out_det    = r_cmd.det;
        n_out_ch     = r_cmd.ch;
        n_out_e      = r_cmd.e;
        n_out_ts     = r_cmd.ts;
        n_out_last   = 1'b1;
        n_out_ovf    = r_cmd.ovf;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_head;
                    if (i_head.above) begin
                        if (r_held_valid) begin
                            n_state = S_HELD;
                        end else if (i_head.last) begin
                            n_state = S_NEW;
                        end else begin
                            n_held_valid = 1'b1;
                            n_held_ch    = i_head.ch;
                            n_held_e     = i_head.e;
                            n_held_ts    = i_head.ts;
                            n_pcnt       = '0;
                        end
                    end else begin
                        // weak non-last hit after a held strong hit is buffered
                        if (i_head.acc && r_held_valid && !i_head.last
                            && (r_pcnt < CNT_W'(MAX_CLUSTER))) begin
                            pw_we  = 1'b1;
                            n_pcnt = r_pcnt + 1'b1;
                        end
                        if (i_head.last) begin
                            if (r_held_valid) begin
                                n_state = S_HELD;
                            end else begin
                                n_pcnt = '0;
                            end
                        end
                    end
                end
            end
            S_HELD: begin
                n_out_ch   = r_held_ch;
                n_out_e    = r_held_e;
                n_out_ts   = r_held_ts;
                n_out_last = !r_cmd.above;
                n_out_ovf  = !r_cmd.above && r_cmd.ovf;
                if (slot_free) begin
                    emit = 1'b1;
                    if (!r_cmd.above) begin
                        // end of cluster without a new strong hit: tail dropped
                        n_held_valid = 1'b0;
                        n_pcnt       = '0;
                        n_state      = S_IDLE;
                    end else if (r_pcnt != '0) begin
                        pr_re   = 1'b1;
                        pr_addr = '0;
                        n_idx   = '0;
                        n_state = S_FLUSH;
                    end else if (r_cmd.last) begin
                        n_state = S_NEW;
                    end else begin
                        n_held_ch = r_cmd.ch;
                        n_held_e  = r_cmd.e;
                        n_held_ts = r_cmd.ts;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                n_out_ch   = pr_data[PEND_W-1 -: CH_W];
                n_out_e    = pr_data[TS_W +: E_W];
                n_out_ts   = pr_data[TS_W-1:0];
                n_out_last = 1'b0;
                n_out_ovf  = 1'b0;
                if (slot_free) begin
                    emit = 1'b1;
                    if (idx_next == r_pcnt) begin
                        n_pcnt = '0;
                        if (r_cmd.last) begin
                            n_state = S_NEW;
                        end else begin
                            n_held_valid = 1'b1;
                            n_held_ch    = r_cmd.ch;
                            n_held_e     = r_cmd.e;
                            n_held_ts    = r_cmd.ts;
                            n_state      = S_IDLE;
                        end
                    end else begin
                        pr_re = 1'b1;
                        n_idx = idx_next;
                    end
                end
            end
            S_NEW: begin
                if (slot_free) begin
                    emit         = 1'b1;
                    n_held_valid = 1'b0;
                    n_pcnt       = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_held_valid <= 1'b0;
            r_pcnt       <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_held_valid <= n_held_valid;
            r_pcnt       <= n_pcnt;
            r_idx        <= n_idx;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_held_ch <= n_held_ch;
        r_held_e  <= n_held_e;
        r_held_ts <= n_held_ts;
        if (emit) begin
            r_out_det  <= n_out_det;
            r_out_ch   <= n_out_ch;
            r_out_e    <= n_out_e;
            r_out_ts   <= n_out_ts;
            r_out_last <= n_out_last;
            r_out_ovf  <= n_out_ovf;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.out_det_id    = r_out_det;
    assign o_res.out_channel   = r_out_ch;
    assign o_res.out_energy    = r_out_e;
    assign o_res.out_timestamp = r_out_ts;
    assign o_res.out_last      = r_out_last;
    assign o_res.out_overflow  = r_out_ovf;
endmodule

// File: rtl/cnet_checker.sv
// Port-level checker for the cluster edge trim block, bound to the top level.
module cnet_checker import cnet_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_hit_ready,
    input logic    i_res_valid,
    input logic    i_res_ready,
    input t_det    i_res_det,
    input t_ch     i_res_ch,
    input t_energy i_res_e,
    input t_ts     i_res_ts,
    input logic    i_res_last,
    input logic    i_res_ovf
);
    // overflow is reported only on the final result of a cluster
    a_ovf_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (!i_res_ovf || i_res_last))
        else $error("overflow flag on a result that is not last");

    // the threshold clearing pass keeps input closed right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_hit_ready)
        else $error("input ready during threshold clearing pass");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid
            && $stable(i_res_det) && $stable(i_res_ch) && $stable(i_res_e)
            && $stable(i_res_ts) && $stable(i_res_last) && $stable(i_res_ovf)))
        else $error("stalled result changed");
endmodule

bind cluster_noise_edge_trim cnet_checker u_cnet_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_hit_ready (i_hit.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_det   (o_res.out_det_id),
    .i_res_ch    (o_res.out_channel),
    .i_res_e     (o_res.out_energy),
    .i_res_ts    (o_res.out_timestamp),
    .i_res_last  (o_res.out_last),
    .i_res_ovf   (o_res.out_overflow)
);

// File: verif/tb_top.sv
// Self-checking testbench for the cluster edge trim block: directed, capacity, random.
`timescale 1ns / 100ps

module tb_top;
    import cnet_pkg::*;

    localparam int LIMIT_CYCLES = 900_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_HITS    = 24;
    localparam int DIR_N        = 22;

    // where the expected results of a table row come from
    typedef enum logic [1:0] {BY_PREDICTOR, NO_RESULT, ECHO_LAST} t_exp_src;

    typedef struct {
        logic    mode;
        t_det    det;
        t_ch     ch;
        t_energy e;
        t_ts     ts;
        logic    last;
    } t_hit_item;

    typedef struct {
        t_det    det;
        t_ch     ch;
        t_energy e;
        t_ts     ts;
        logic    last;
        logic    ovf;
    } t_kept_hit;

    typedef struct {
        logic     mode;
        t_det     det;
        t_ch      ch;
        t_energy  e;
        t_ts      ts;
        logic     last;
        t_exp_src src;
    } t_dir_row;

    t_dir_row dir_tbl [DIR_N] = '{
        '{MODE_HIT,  4'd0,  10'd0,    24'd1,      48'h0,            1'b1, ECHO_LAST},
        '{MODE_HIT,  4'd15, 10'd1023, 24'd0,      48'hFFFFFFFFFFFF, 1'b1, NO_RESULT},
        '{MODE_HIT,  4'd5,  10'd5,    24'h800000, 48'd123,          1'b1, NO_RESULT},
        '{MODE_HIT,  4'd15, 10'd1023, 24'h7FFFFF, 48'hFFFFFFFFFFFF, 1'b1, ECHO_LAST},
        '{MODE_LOAD, 4'd0,  10'd10,   24'd100,    48'h0,            1'b0, NO_RESULT},
        '{MODE_HIT,  4'd1,  10'd10,   24'd100,    48'd10,           1'b1, NO_RESULT},
        '{MODE_HIT,  4'd2,  10'd10,   24'd101,    48'd11,           1'b1, ECHO_LAST},
        '{MODE_LOAD, 4'd15, 10'd1023, 24'h800000, 48'hFFFFFFFFFFFF, 1'b1, NO_RESULT},
        '{MODE_HIT,  4'd0,  10'd1023, 24'h800001, 48'h0,            1'b1, ECHO_LAST},
        '{MODE_HIT,  4'd0,  10'd1023, 24'h800000, 48'h0,            1'b1, NO_RESULT},
        '{MODE_LOAD, 4'd0,  10'd20,   24'h7FFFFF, 48'h0,            1'b0, NO_RESULT},
        '{MODE_HIT,  4'd4,  10'd20,   24'h7FFFFF, 48'd20,           1'b1, NO_RESULT},
        // weak lead, strong, weak middle, strong, weak tail
        '{MODE_HIT,  4'd3,  10'd10,   24'd5,      48'd30,           1'b0, BY_PREDICTOR},
        '{MODE_HIT,  4'd3,  10'd11,   24'd200,    48'd31,           1'b0, BY_PREDICTOR},
        '{MODE_HIT,  4'd3,  10'd10,   24'd50,     48'd32,           1'b0, BY_PREDICTOR},
        '{MODE_HIT,  4'd3,  10'd12,   24'hFFFFFD, 48'd33,           1'b0, BY_PREDICTOR},
        '{MODE_HIT,  4'd3,  10'd13,   24'd7,      48'd34,           1'b0, BY_PREDICTOR},
        '{MODE_HIT,  4'd3,  10'd10,   24'd0,      48'd35,           1'b0, BY_PREDICTOR},
        '{MODE_HIT,  4'd3,  10'd14,   24'd0,      48'd36,           1'b1, BY_PREDICTOR},
        // load in mid cluster leaves the cluster alone, turns the tail hit weak
        '{MODE_HIT,  4'd7,  10'd30,   24'd9,      48'd40,           1'b0, BY_PREDICTOR},
        '{MODE_LOAD, 4'd15, 10'd30,   24'd50,     48'hFFFFFFFFFFFF, 1'b1, NO_RESULT},
        '{MODE_HIT,  4'd7,  10'd30,   24'd9,      48'd41,           1'b1, BY_PREDICTOR}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    cnet_hit_if hit_if ();
    cnet_res_if res_if ();

    cluster_noise_edge_trim DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hit   (hit_if),
        .o_res   (res_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    t_energy thr_tbl [CHANNELS];
    t_ch     wk_ch   [MAX_CLUSTER];
    t_energy wk_e    [MAX_CLUSTER];
    t_ts     wk_ts   [MAX_CLUSTER];
    int      wk_n;
    bit      hold_ok;
    t_ch     hold_ch;
    t_energy hold_e;
    t_ts     hold_ts;
    int      hits_seen;
    bit      drop_seen;

    t_kept_hit fresh_q [$];
    t_kept_hit kept_hits_due [$];

    int gap_pct;
    int stall_pct;
    int stall_left;
    int err_cnt;
    int n_hits, n_loads, n_clusters, n_ovf_clusters, n_checked;

    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3);
    endfunction

    function automatic t_kept_hit kept(t_det d, t_ch c, t_energy e, t_ts ts, logic lst,
                                       logic ov);
        t_kept_hit k;
        k.det  = d;
        k.ch   = c;
        k.e    = e;
        k.ts   = ts;
        k.last = lst;
        k.ovf  = ov;
        return k;
    endfunction

    function automatic t_hit_item mk_hit(logic mode, t_det d, t_ch c, t_energy e, t_ts ts,
                                         logic lst);
        t_hit_item h;
        h.mode = mode;
        h.det  = d;
        h.ch   = c;
        h.e    = e;
        h.ts   = ts;
        h.last = lst;
        return h;
    endfunction

    // Works out the kept hits released by one accepted item into fresh_q.
    function automatic void trim_hit(t_hit_item h);
        bit      taken;
        bit      above;
        t_energy lim;
        above = 1'b0;
        if (h.mode == MODE_LOAD) begin
            if (h.ch < CHANNELS)
                thr_tbl[h.ch] = h.e;
            return;
        end
        if (hits_seen >= MAX_CLUSTER) begin
            drop_seen = 1'b1;
            taken = 1'b0;
        end else begin
            hits_seen++;
            taken = 1'b1;
        end
        if (taken) begin
            lim = '0;
            if (h.ch < CHANNELS)
                lim = thr_tbl[h.ch];
            above = h.e > lim;
            if (above) begin
                if (hold_ok) begin
                    fresh_q.push_back(kept(h.det, hold_ch, hold_e, hold_ts, 1'b0, 1'b0));
                    for (int i = 0; i < wk_n; i++)
                        fresh_q.push_back(kept(h.det, wk_ch[i], wk_e[i], wk_ts[i], 1'b0, 1'b0));
                end
                wk_n = 0;
                if (h.last) begin
                    fresh_q.push_back(kept(h.det, h.ch, h.e, h.ts, 1'b1, drop_seen));
                    hold_ok = 1'b0;
                end else begin
                    hold_ok = 1'b1;
                    hold_ch = h.ch;
                    hold_e  = h.e;
                    hold_ts = h.ts;
                end
            end else if (hold_ok && !h.last && wk_n < MAX_CLUSTER) begin
                wk_ch[wk_n] = h.ch;
                wk_e[wk_n]  = h.e;
                wk_ts[wk_n] = h.ts;
                wk_n++;
            end
        end
        if (h.last) begin
            // end mark on a weak or dropped hit releases the held strong hit
            if (!(taken && above) && hold_ok)
                fresh_q.push_back(kept(h.det, hold_ch, hold_e, hold_ts, 1'b1, drop_seen));
            if (drop_seen)
                n_ovf_clusters++;
            n_clusters++;
            hold_ok   = 1'b0;
            wk_n      = 0;
            hits_seen = 0;
            drop_seen = 1'b0;
        end
    endfunction

    // Entered after an accept edge (or an idle step); returns at the accept edge.
    task automatic send_hit(t_hit_item h, t_exp_src src);
        int gap;
        gap = ($urandom_range(0, 99) < gap_pct) ? idle_len() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            hit_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        hit_if.valid           <= 1'b1;
        hit_if.mode            <= h.mode;
        hit_if.det_id          <= h.det;
        hit_if.channel         <= h.ch;
        hit_if.energy          <= h.e;
        hit_if.timestamp       <= h.ts;
        hit_if.last_in_cluster <= h.last;
        do @(posedge i_clk); while (hit_if.ready !== 1'b1);
        trim_hit(h);
        case (src)
            NO_RESULT: fresh_q.delete();
            ECHO_LAST: begin
                fresh_q.delete();
                fresh_q.push_back(kept(h.det, h.ch, h.e, h.ts, 1'b1, 1'b0));
            end
            default: ;
        endcase
        while (fresh_q.size() != 0)
            kept_hits_due.push_back(fresh_q.pop_front());
        if (h.mode == MODE_LOAD)
            n_loads++;
        else
            n_hits++;
    endtask

    task automatic hit_idle();
        @(negedge i_clk);
        hit_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (kept_hits_due.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_ch rand_channel();
        if ($urandom_range(0, 9) < 7)
            return t_ch'($urandom_range(0, 15));
        return t_ch'($urandom_range(0, CHANNELS - 1));
    endfunction

    function automatic t_energy rand_energy(t_ch c);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return t_energy'($urandom());
        if (sel < 20)
            return thr_tbl[c];
        if (sel < 30)
            return thr_tbl[c] + t_energy'(1);
        return t_energy'(int'($urandom_range(0, 900)) - 300);
    endfunction

    function automatic t_energy rand_thr();
        if ($urandom_range(0, 19) == 0)
            return t_energy'($urandom());
        return t_energy'(int'($urandom_range(0, 400)) - 100);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    task automatic send_cluster(int len);
        t_det d;
        t_ch  c;
        d = t_det'($urandom());
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 24) == 0)
                send_hit(mk_hit(MODE_LOAD, t_det'($urandom()), rand_channel(), rand_thr(),
                                t_ts'({$urandom(), $urandom()}), 1'($urandom())), BY_PREDICTOR);
            c = rand_channel();
            send_hit(mk_hit(MODE_HIT, d, c, rand_energy(c), t_ts'({$urandom(), $urandom()}),
                            i == len - 1), BY_PREDICTOR);
        end
    endtask

    // result side: random back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            res_if.ready <= 1'b0;
            stall_left = idle_len() - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_kept_hit want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (kept_hits_due.size() == 0) begin
                $error("unexpected item: det %0d channel %0d energy %0d",
                       res_if.out_det_id, res_if.out_channel, res_if.out_energy);
                err_cnt++;
            end else begin
                want = kept_hits_due.pop_front();
                n_checked++;
                if (res_if.out_det_id !== want.det) begin
                    $error("out_det_id: expected %0d, got %0d", want.det, res_if.out_det_id);
                    err_cnt++;
                end
                if (res_if.out_channel !== want.ch) begin
                    $error("out_channel: expected %0d, got %0d", want.ch, res_if.out_channel);
                    err_cnt++;
                end
                if (res_if.out_energy !== want.e) begin
                    $error("out_energy: expected %0d, got %0d", want.e, res_if.out_energy);
                    err_cnt++;
                end
                if (res_if.out_timestamp !== want.ts) begin
                    $error("out_timestamp: expected %0h, got %0h", want.ts,
                           res_if.out_timestamp);
                    err_cnt++;
                end
                if (res_if.out_last !== want.last) begin
                    $error("out_last: expected %0b, got %0b", want.last, res_if.out_last);
                    err_cnt++;
                end
                if (res_if.out_overflow !== want.ovf) begin
                    $error("out_overflow: expected %0b, got %0b", want.ovf,
                           res_if.out_overflow);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    initial begin
        int cyc;
        cyc = 0;
        while (cyc < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int len;
        int base;
        bit paused;
        foreach (thr_tbl[i])
            thr_tbl[i] = '0;
        wk_n      = 0;
        hold_ok   = 1'b0;
        hold_ch   = '0;
        hold_e    = '0;
        hold_ts   = '0;
        hits_seen = 0;
        drop_seen = 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        stall_left = 0;
        err_cnt   = 0;
        n_hits = 0;
        n_loads = 0;
        n_clusters = 0;
        n_ovf_clusters = 0;
        n_checked = 0;
        paused = 1'b0;
        base = 0;

        i_rst_n                = 1'b0;
        hit_if.valid           = 1'b0;
        hit_if.mode            = MODE_HIT;
        hit_if.det_id          = '0;
        hit_if.channel         = '0;
        hit_if.energy          = '0;
        hit_if.timestamp       = '0;
        hit_if.last_in_cluster = 1'b0;
        res_if.ready           = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, no idling on either side
        foreach (dir_tbl[r])
            send_hit(mk_hit(dir_tbl[r].mode, dir_tbl[r].det, dir_tbl[r].ch, dir_tbl[r].e,
                            dir_tbl[r].ts, dir_tbl[r].last), dir_tbl[r].src);
        hit_idle();
        wait_drained();

        // capacity: overflow with held hit released by a dropped end mark,
        // a full 32-result release, and an all-weak overflow that loses its flag
        gap_pct   = 20;
        stall_pct = 20;
        for (int i = 0; i < 34; i++)
            send_hit(mk_hit(MODE_HIT, 4'd9, 10'd40,
                            (i == 0 || i == 31 || i == 33) ? t_energy'(50 + i) : t_energy'(-i),
                            t_ts'(9000 + i), i == 33), BY_PREDICTOR);
        for (int i = 0; i < 32; i++)
            send_hit(mk_hit(MODE_HIT, 4'd10, 10'd40,
                            (i == 0 || i == 31) ? t_energy'(70) : t_energy'(-i),
                            t_ts'(10000 + i), i == 31), BY_PREDICTOR);
        for (int i = 0; i < 35; i++)
            send_hit(mk_hit(MODE_HIT, 4'd11, 10'd40, t_energy'(0), t_ts'(11000 + i),
                            i == 34), BY_PREDICTOR);

        // thresholds for the busy channel pool
        for (int c = 0; c < 16; c++)
            send_hit(mk_hit(MODE_LOAD, t_det'($urandom()), t_ch'(c), rand_thr(),
                            t_ts'({$urandom(), $urandom()}), 1'($urandom())), BY_PREDICTOR);

        base = n_hits;
        while (n_hits < base + RAND_HITS) begin
            gap_pct   = pick_pct();
            stall_pct = pick_pct();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
            if (len > base + RAND_HITS - n_hits)
                len = base + RAND_HITS - n_hits;
            send_cluster(len);
            if (!paused && n_hits >= base + RAND_HITS / 2) begin
                hit_idle();
                wait_drained();
                paused = 1'b1;
            end
        end

        hit_idle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d hits and %0d threshold loads in %0d clusters",
                 n_hits, n_loads, n_clusters);
        $display("(%0d over capacity); %0d trimmed items compared", n_ovf_clusters, n_checked);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
